@@ hw/rtl/mpm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the multi-pattern matcher.
// Holds mode and result codes, the controller states and the command/status structs.
// No dependencies.
package mpm_pkg;

  localparam int MAX_NODES_D    = 256;
  localparam int MAX_PATTERNS_D = 32;
  localparam int ALPHABET_D     = 256;
  localparam int POS_WIDTH_D    = 16;

  localparam int RESULT_CAP = 32;
  localparam int ID_W       = 5;
  localparam int SYM_IN_W   = 8;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_BUILD  = 2'd2;
  localparam logic [1:0] MODE_SCAN   = 2'd3;

  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_MATCH    = 2'd1;
  localparam logic [1:0] KIND_BUILD    = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_INS_ISSUE, ST_INS_RD, ST_INS_END, ST_INS_TERM,
    ST_B_INIT, ST_B_RDC, ST_B_C, ST_B_F, ST_B_RDW, ST_B_WC, ST_B_T,
    ST_B_NEXTU, ST_B_DQ, ST_B_DONE,
    ST_S_RD, ST_S_C, ST_S_F, ST_S_FIN, ST_S_T, ST_S_PRD, ST_S_PE
  } state_t;

  typedef enum logic [4:0] {
    OP_CLR, OP_IDLE, OP_INS_ISSUE, OP_INS_RD, OP_INS_END, OP_INS_TERM,
    OP_B_INIT, OP_B_RDC, OP_B_C, OP_B_F, OP_B_RDW, OP_B_WC, OP_B_T,
    OP_B_NEXTU, OP_B_DQ, OP_B_DONE,
    OP_S_RD, OP_S_C, OP_S_F, OP_S_FIN, OP_S_T, OP_S_PRD, OP_S_PE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic take;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic ov;
    logic end_flag;
    logic child_zero;
    logic root;
    logic s_last;
    logic f_zero;
    logic cur_zero;
    logic q_empty;
    logic term;
    logic olink_zero;
    logic cap_last;
    logic out_free;
  } stat_t;

endpackage

@@ hw/rtl/multi_pattern_matcher_all_hits.sv @@
`timescale 1ns / 1ps
// Aho-Corasick matcher, all hits, one beat at a time, paced by the child-table port.
// Insert beat: read the child entry, follow it or add a node, and on a pattern's last byte
// mark the end node; after a node overflow only the last byte acts, reporting the overflow.
// Scan beat: read the child entry, follow failure links, report hits along output links.
// Build: breadth-first pass that sets failure and output links. Beats wait on output stalls.
// Reset and a clear beat start a clearing pass first. Depends on mpm_pkg, mpm_ctrl, mpm_dp.
module multi_pattern_matcher_all_hits #(
  parameter int MAX_NODES    = mpm_pkg::MAX_NODES_D,
  parameter int MAX_PATTERNS = mpm_pkg::MAX_PATTERNS_D,
  parameter int ALPHABET     = mpm_pkg::ALPHABET_D,
  parameter int POS_WIDTH    = mpm_pkg::POS_WIDTH_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_mode,
  input  logic [mpm_pkg::SYM_IN_W-1:0]  in_symbol,
  input  logic                          in_pattern_end,
  input  logic [mpm_pkg::ID_W-1:0]      in_pattern_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [mpm_pkg::ID_W-1:0]      out_match_id,
  output logic [POS_WIDTH-1:0]          out_position,
  output logic                          out_run_last
);
  import mpm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mpm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_mode, .in_pattern_end, .in_ready, .stat, .cmd);

  mpm_dp #(
    .MAX_NODES(MAX_NODES), .MAX_PATTERNS(MAX_PATTERNS),
    .ALPHABET(ALPHABET), .POS_WIDTH(POS_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_mode, .in_symbol, .in_pattern_end, .in_pattern_tag,
    .out_valid, .out_ready, .out_kind, .out_match_id, .out_position, .out_run_last);

endmodule

@@ hw/rtl/mpm_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/mpm_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the matcher: clear pass, insert, link build and scan walks.
// Depends on mpm_pkg.
module mpm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_mode,
  input  logic          in_pattern_end,
  output logic          in_ready,
  input  mpm_pkg::stat_t stat,
  output mpm_pkg::cmd_t  cmd
);
  import mpm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:       if (stat.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_CLEAR:  state_nxt = ST_CLR;
            MODE_INSERT: begin
              if (!stat.ov) state_nxt = ST_INS_ISSUE;
              else if (in_pattern_end) state_nxt = ST_INS_END;
              else state_nxt = ST_IDLE;
            end
            MODE_BUILD:  state_nxt = ST_B_INIT;
            default:     state_nxt = ST_S_RD;
          endcase
        end
      end
      ST_INS_ISSUE: state_nxt = ST_INS_RD;
      ST_INS_RD:    state_nxt = stat.end_flag ? ST_INS_END : ST_IDLE;
      ST_INS_END: begin
        if (!stat.ov) state_nxt = ST_INS_TERM;
        else if (stat.out_free) state_nxt = ST_IDLE;
      end
      ST_INS_TERM:  if (stat.out_free) state_nxt = ST_IDLE;
      ST_B_INIT:    state_nxt = ST_B_RDC;
      ST_B_RDC:     state_nxt = ST_B_C;
      ST_B_C: begin
        if (!stat.child_zero && !stat.root) state_nxt = ST_B_F;
        else state_nxt = stat.s_last ? ST_B_NEXTU : ST_B_RDC;
      end
      ST_B_F:       state_nxt = ST_B_RDW;
      ST_B_RDW:     state_nxt = ST_B_WC;
      ST_B_WC:      state_nxt = (!stat.child_zero || stat.f_zero) ? ST_B_T : ST_B_F;
      ST_B_T:       state_nxt = stat.s_last ? ST_B_NEXTU : ST_B_RDC;
      ST_B_NEXTU:   state_nxt = stat.q_empty ? ST_B_DONE : ST_B_DQ;
      ST_B_DQ:      state_nxt = ST_B_RDC;
      ST_B_DONE:    if (stat.out_free) state_nxt = ST_IDLE;
      ST_S_RD:      state_nxt = ST_S_C;
      ST_S_C: begin
        if (!stat.child_zero || stat.cur_zero) state_nxt = ST_S_FIN;
        else state_nxt = ST_S_F;
      end
      ST_S_F:       state_nxt = ST_S_RD;
      ST_S_FIN:     state_nxt = ST_S_T;
      ST_S_T: begin
        if (!stat.term || stat.out_free) begin
          state_nxt = stat.olink_zero ? ST_IDLE : ST_S_PRD;
        end
      end
      ST_S_PRD:     state_nxt = ST_S_PE;
      ST_S_PE: begin
        if (stat.out_free) begin
          state_nxt = (stat.olink_zero || stat.cap_last) ? ST_IDLE : ST_S_PRD;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    cmd.take = (state_r == ST_IDLE) && in_valid;
    cmd.emit = stat.out_free &&
               (((state_r == ST_INS_END) && stat.ov) || (state_r == ST_INS_TERM) ||
                (state_r == ST_B_DONE) || ((state_r == ST_S_T) && stat.term) ||
                (state_r == ST_S_PE));
    unique case (state_r)
      ST_CLR:       cmd.op = OP_CLR;
      ST_IDLE:      cmd.op = OP_IDLE;
      ST_INS_ISSUE: cmd.op = OP_INS_ISSUE;
      ST_INS_RD:    cmd.op = OP_INS_RD;
      ST_INS_END:   cmd.op = OP_INS_END;
      ST_INS_TERM:  cmd.op = OP_INS_TERM;
      ST_B_INIT:    cmd.op = OP_B_INIT;
      ST_B_RDC:     cmd.op = OP_B_RDC;
      ST_B_C:       cmd.op = OP_B_C;
      ST_B_F:       cmd.op = OP_B_F;
      ST_B_RDW:     cmd.op = OP_B_RDW;
      ST_B_WC:      cmd.op = OP_B_WC;
      ST_B_T:       cmd.op = OP_B_T;
      ST_B_NEXTU:   cmd.op = OP_B_NEXTU;
      ST_B_DQ:      cmd.op = OP_B_DQ;
      ST_B_DONE:    cmd.op = OP_B_DONE;
      ST_S_RD:      cmd.op = OP_S_RD;
      ST_S_C:       cmd.op = OP_S_C;
      ST_S_F:       cmd.op = OP_S_F;
      ST_S_FIN:     cmd.op = OP_S_FIN;
      ST_S_T:       cmd.op = OP_S_T;
      ST_S_PRD:     cmd.op = OP_S_PRD;
      ST_S_PE:      cmd.op = OP_S_PE;
      default:      cmd.op = OP_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/mpm_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the matcher: trie and link memories, walk registers and result register.
// Depends on mpm_pkg and mpm_ram.
module mpm_dp #(
  parameter int MAX_NODES    = mpm_pkg::MAX_NODES_D,
  parameter int MAX_PATTERNS = mpm_pkg::MAX_PATTERNS_D,
  parameter int ALPHABET     = mpm_pkg::ALPHABET_D,
  parameter int POS_WIDTH    = mpm_pkg::POS_WIDTH_D
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpm_pkg::cmd_t                 cmd,
  output mpm_pkg::stat_t                stat,
  input  logic [1:0]                    in_mode,
  input  logic [mpm_pkg::SYM_IN_W-1:0]  in_symbol,
  input  logic                          in_pattern_end,
  input  logic [mpm_pkg::ID_W-1:0]      in_pattern_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [mpm_pkg::ID_W-1:0]      out_match_id,
  output logic [POS_WIDTH-1:0]          out_position,
  output logic                          out_run_last
);
  import mpm_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int SW  = $clog2(ALPHABET);
  localparam int CD  = MAX_NODES * ALPHABET;
  localparam int CAW = $clog2(CD);
  localparam int HW  = $clog2(RESULT_CAP);

  function automatic logic [CAW-1:0] caddr(input logic [NW-1:0] node, input logic [SW-1:0] s);
    return CAW'(node) * CAW'(ALPHABET) + CAW'(s);
  endfunction

  function automatic logic [SW-1:0] fold_sym(input logic [SYM_IN_W-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (v == SYM_IN_W'(i)) r = SW'(i % ALPHABET);
    end
    return r;
  endfunction

  function automatic logic [ID_W-1:0] fold_tag(input logic [ID_W-1:0] v);
    logic [ID_W-1:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v == ID_W'(i)) r = ID_W'(i % MAX_PATTERNS);
    end
    return r;
  endfunction

  // Memory ports.
  logic           ch_we, ch_re;
  logic [CAW-1:0] ch_wa, ch_ra;
  logic [NW-1:0]  ch_wd, ch_rd;
  logic           fl_we, fl_re, ol_we, ol_re, tm_we, tm_re, pt_we, pt_re, q_we, q_re;
  logic [NW-1:0]  fl_wa, fl_ra, fl_wd, fl_rd;
  logic [NW-1:0]  ol_wa, ol_ra, ol_wd, ol_rd;
  logic [NW-1:0]  tm_wa, tm_ra, pt_wa, pt_ra, q_wa, q_ra, q_wd, q_rd;
  logic           tm_wd, tm_rd;
  logic [ID_W-1:0] pt_wd, pt_rd;

  mpm_ram #(.WIDTH(NW), .DEPTH(CD)) u_child (
    .clk, .we(ch_we), .waddr(ch_wa), .wdata(ch_wd), .re(ch_re), .raddr(ch_ra), .rdata(ch_rd));
  mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk, .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .re(fl_re), .raddr(fl_ra), .rdata(fl_rd));
  mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_olink (
    .clk, .we(ol_we), .waddr(ol_wa), .wdata(ol_wd), .re(ol_re), .raddr(ol_ra), .rdata(ol_rd));
  mpm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_term (
    .clk, .we(tm_we), .waddr(tm_wa), .wdata(tm_wd), .re(tm_re), .raddr(tm_ra), .rdata(tm_rd));
  mpm_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_pat (
    .clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .re(pt_re), .raddr(pt_ra), .rdata(pt_rd));
  mpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk, .we(q_we), .waddr(q_wa), .wdata(q_wd), .re(q_re), .raddr(q_ra), .rdata(q_rd));

  // Control registers.
  logic [CAW-1:0] clr_r, clr_nxt;
  logic [NCW-1:0] node_cnt_r, node_cnt_nxt;
  logic [NW-1:0]  cursor_r, cursor_nxt, scan_r, scan_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic           ov_r, ov_nxt, out_valid_r, out_valid_nxt;
  // Working registers.
  logic [SW-1:0]  sym_r, sym_nxt, s_r, s_nxt;
  logic           end_r, end_nxt, root_r, root_nxt;
  logic [ID_W-1:0] tag_r, tag_nxt;
  logic [NW-1:0]  cur_r, cur_nxt, u_r, u_nxt, f_r, f_nxt, c_r, c_nxt, fc_r, fc_nxt;
  logic [NW-1:0]  p_r, p_nxt;
  logic [NCW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [HW-1:0]  n_r, n_nxt;
  logic [POS_WIDTH-1:0] hit_r, hit_nxt;
  logic [1:0]     kind_r, kind_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [POS_WIDTH-1:0] opos_r, opos_nxt;
  logic           last_r, last_nxt;

  logic out_free;
  logic [SW-1:0] s_adv;

  assign out_free = !out_valid_r || out_ready;
  assign s_adv    = (s_r == SW'(ALPHABET - 1)) ? '0 : s_r + 1'b1;

  always_comb begin
    clr_nxt = clr_r;  node_cnt_nxt = node_cnt_r;  cursor_nxt = cursor_r;
    scan_nxt = scan_r;  pos_nxt = pos_r;  ov_nxt = ov_r;
    sym_nxt = sym_r;  s_nxt = s_r;  end_nxt = end_r;  root_nxt = root_r;  tag_nxt = tag_r;
    cur_nxt = cur_r;  u_nxt = u_r;  f_nxt = f_r;  c_nxt = c_r;  fc_nxt = fc_r;  p_nxt = p_r;
    head_nxt = head_r;  tail_nxt = tail_r;  n_nxt = n_r;  hit_nxt = hit_r;
    kind_nxt = kind_r;  id_nxt = id_r;  opos_nxt = opos_r;  last_nxt = last_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    ch_we = 1'b0; ch_wa = '0; ch_wd = '0; ch_re = 1'b0; ch_ra = '0;
    fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_re = 1'b0; fl_ra = '0;
    ol_we = 1'b0; ol_wa = '0; ol_wd = '0; ol_re = 1'b0; ol_ra = '0;
    tm_we = 1'b0; tm_wa = '0; tm_wd = 1'b0; tm_re = 1'b0; tm_ra = '0;
    pt_we = 1'b0; pt_wa = '0; pt_wd = '0; pt_re = 1'b0; pt_ra = '0;
    q_we = 1'b0; q_wa = '0; q_wd = '0; q_re = 1'b0; q_ra = '0;

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      kind_nxt = KIND_MATCH;
      id_nxt   = pt_rd;
      opos_nxt = '0;
      last_nxt = 1'b1;
    end

    unique case (cmd.op)
      OP_CLR: begin
        ch_we = 1'b1;
        ch_wa = clr_r;
        if (clr_r < CAW'(MAX_NODES)) begin
          fl_we = 1'b1;  fl_wa = clr_r[NW-1:0];
          ol_we = 1'b1;  ol_wa = clr_r[NW-1:0];
          tm_we = 1'b1;  tm_wa = clr_r[NW-1:0];
        end
        clr_nxt = clr_r + 1'b1;
      end
      OP_IDLE: begin
        if (cmd.take) begin
          sym_nxt = fold_sym(in_symbol);
          end_nxt = in_pattern_end;
          tag_nxt = fold_tag(in_pattern_tag);
          cur_nxt = scan_r;
          if (in_mode == MODE_CLEAR) begin
            node_cnt_nxt = NCW'(1);
            cursor_nxt = '0;
            scan_nxt = '0;
            pos_nxt = '0;
            ov_nxt = 1'b0;
            clr_nxt = '0;
          end
        end
      end
      OP_INS_ISSUE: begin
        ch_re = 1'b1;
        ch_ra = caddr(cursor_r, sym_r);
      end
      OP_INS_RD: begin
        if (ch_rd == '0) begin
          if (node_cnt_r < NCW'(MAX_NODES)) begin
            ch_we = 1'b1;
            ch_wa = caddr(cursor_r, sym_r);
            ch_wd = node_cnt_r[NW-1:0];
            cursor_nxt = node_cnt_r[NW-1:0];
            node_cnt_nxt = node_cnt_r + 1'b1;
          end else begin
            ov_nxt = 1'b1;
          end
        end else begin
          cursor_nxt = ch_rd;
        end
      end
      OP_INS_END: begin
        if (!ov_r) begin
          tm_re = 1'b1;  tm_ra = cursor_r;
          pt_re = 1'b1;  pt_ra = cursor_r;
        end else if (cmd.emit) begin
          kind_nxt = KIND_OVERFLOW;
          id_nxt = '0;
          ov_nxt = 1'b0;
          cursor_nxt = '0;
        end
      end
      OP_INS_TERM: begin
        if (cmd.emit) begin
          // The first insert of a pattern owns the id; duplicates report it.
          if (!tm_rd) begin
            tm_we = 1'b1;  tm_wa = cursor_r;  tm_wd = 1'b1;
            pt_we = 1'b1;  pt_wa = cursor_r;  pt_wd = tag_r;
          end
          kind_nxt = KIND_INSERT;
          id_nxt = tm_rd ? pt_rd : tag_r;
          cursor_nxt = '0;
        end
      end
      OP_B_INIT: begin
        head_nxt = '0;  tail_nxt = '0;  u_nxt = '0;  s_nxt = '0;  root_nxt = 1'b1;
      end
      OP_B_RDC: begin
        ch_re = 1'b1;
        ch_ra = caddr(u_r, s_r);
      end
      OP_B_C: begin
        if (ch_rd != '0 && root_r) begin
          fl_we = 1'b1;  fl_wa = ch_rd;
          ol_we = 1'b1;  ol_wa = ch_rd;
          q_we = 1'b1;   q_wa = tail_r[NW-1:0];  q_wd = ch_rd;
          tail_nxt = tail_r + 1'b1;
        end else if (ch_rd != '0) begin
          c_nxt = ch_rd;
          fl_re = 1'b1;
          fl_ra = u_r;
        end
        if (ch_rd == '0 || root_r) s_nxt = s_adv;
      end
      OP_B_F: f_nxt = fl_rd;
      OP_B_RDW: begin
        ch_re = 1'b1;
        ch_ra = caddr(f_r, s_r);
      end
      OP_B_WC: begin
        if (ch_rd != '0 || f_r == '0) begin
          fc_nxt = ch_rd;
          tm_re = 1'b1;  tm_ra = ch_rd;
          ol_re = 1'b1;  ol_ra = ch_rd;
        end else begin
          fl_re = 1'b1;
          fl_ra = f_r;
        end
      end
      OP_B_T: begin
        fl_we = 1'b1;  fl_wa = c_r;  fl_wd = fc_r;
        ol_we = 1'b1;  ol_wa = c_r;  ol_wd = tm_rd ? fc_r : ol_rd;
        q_we = 1'b1;   q_wa = tail_r[NW-1:0];  q_wd = c_r;
        tail_nxt = tail_r + 1'b1;
        s_nxt = s_adv;
      end
      OP_B_NEXTU: begin
        root_nxt = 1'b0;
        q_re = 1'b1;
        q_ra = head_r[NW-1:0];
      end
      OP_B_DQ: begin
        u_nxt = q_rd;
        head_nxt = head_r + 1'b1;
      end
      OP_B_DONE: begin
        if (cmd.emit) begin
          kind_nxt = KIND_BUILD;
          id_nxt = '0;
          scan_nxt = '0;
          pos_nxt = '0;
        end
      end
      OP_S_RD: begin
        ch_re = 1'b1;
        ch_ra = caddr(cur_r, sym_r);
      end
      OP_S_C: begin
        if (ch_rd != '0) begin
          cur_nxt = ch_rd;
        end else begin
          fl_re = 1'b1;
          fl_ra = cur_r;
        end
      end
      OP_S_F: cur_nxt = fl_rd;
      OP_S_FIN: begin
        scan_nxt = cur_r;
        hit_nxt = pos_r;
        pos_nxt = pos_r + 1'b1;
        tm_re = 1'b1;  tm_ra = cur_r;
        pt_re = 1'b1;  pt_ra = cur_r;
        ol_re = 1'b1;  ol_ra = cur_r;
        n_nxt = '0;
      end
      OP_S_T: begin
        p_nxt = ol_rd;
        if (cmd.emit) begin
          opos_nxt = hit_r;
          last_nxt = (ol_rd == '0);
          n_nxt = HW'(1);
        end
      end
      OP_S_PRD: begin
        pt_re = 1'b1;  pt_ra = p_r;
        ol_re = 1'b1;  ol_ra = p_r;
      end
      OP_S_PE: begin
        if (cmd.emit) begin
          opos_nxt = hit_r;
          // Hits past the cap are dropped, so the cap-th report closes the run.
          last_nxt = (ol_rd == '0) || (n_r == HW'(RESULT_CAP - 1));
          n_nxt = n_r + 1'b1;
          p_nxt = ol_rd;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      node_cnt_r <= NCW'(1);
      cursor_r <= '0;
      scan_r <= '0;
      pos_r <= '0;
      ov_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_r <= clr_nxt;
      node_cnt_r <= node_cnt_nxt;
      cursor_r <= cursor_nxt;
      scan_r <= scan_nxt;
      pos_r <= pos_nxt;
      ov_r <= ov_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;  s_r <= s_nxt;  end_r <= end_nxt;  root_r <= root_nxt;
    tag_r <= tag_nxt;  cur_r <= cur_nxt;  u_r <= u_nxt;  f_r <= f_nxt;
    c_r <= c_nxt;  fc_r <= fc_nxt;  p_r <= p_nxt;  head_r <= head_nxt;
    tail_r <= tail_nxt;  n_r <= n_nxt;  hit_r <= hit_nxt;
    kind_r <= kind_nxt;  id_r <= id_nxt;  opos_r <= opos_nxt;  last_r <= last_nxt;
  end

  always_comb begin
    stat.clr_done   = (clr_r == CAW'(CD - 1));
    stat.ov         = ov_r;
    stat.end_flag   = end_r;
    stat.child_zero = (ch_rd == '0);
    stat.root       = root_r;
    stat.s_last     = (s_r == SW'(ALPHABET - 1));
    stat.f_zero     = (f_r == '0);
    stat.cur_zero   = (cur_r == '0);
    stat.q_empty    = (head_r == tail_r);
    stat.term       = tm_rd;
    stat.olink_zero = (ol_rd == '0);
    stat.cap_last   = (n_r == HW'(RESULT_CAP - 1));
    stat.out_free   = out_free;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = kind_r;
  assign out_match_id = id_r;
  assign out_position = opos_r;
  assign out_run_last = last_r;

endmodule

@@ hw/rtl/mpm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the matcher, bound to the top level.
// Depends on mpm_pkg and multi_pattern_matcher_all_hits.
module mpm_checker #(
  parameter int POS_WIDTH = mpm_pkg::POS_WIDTH_D
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [1:0]                   in_mode,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_kind,
  input logic [mpm_pkg::ID_W-1:0]     out_match_id,
  input logic [POS_WIDTH-1:0]         out_position,
  input logic                         out_run_last
);
  import mpm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_match_id) &&
    $stable(out_position) && $stable(out_run_last))
    else $error("result beat changed while stalled");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_CLEAR |=> !in_ready)
    else $error("input taken during clearing pass");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_MATCH |-> out_run_last)
    else $error("non-match result without run_last");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_BUILD || out_kind == KIND_OVERFLOW) |->
    out_match_id == '0 && out_position == '0)
    else $error("build or overflow result carries id or position");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multi_pattern_matcher_all_hits mpm_checker #(.POS_WIDTH(POS_WIDTH)) u_mpm_checker (.*);
